// ===== hw/rtl/thrmix_pkg.sv =====
// ----------------------------------------------------------------------------
// thrmix_pkg
// Widths, mixing matrix and pipeline types of the thrust allocation mixer.
// ----------------------------------------------------------------------------
package thrmix_pkg;

    localparam int AXES      = 6;
    localparam int THRUSTERS = 8;

    localparam int CMD_W   = 8;    // motion demand
    localparam int SUM_W   = 11;   // signed mix sum, -767..767
    localparam int MAG_W   = 10;   // magnitude of a sum and the common divisor
    localparam int DUTY_W  = 15;   // duty ceiling, Q0.15 magnitude
    localparam int PROD_W  = MAG_W + DUTY_W;
    localparam int OUT_W   = 16;
    localparam int MASK_W  = 8;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [MAG_W-1:0]  UNIT_DEMAND   = MAG_W'(127);
    localparam logic [DUTY_W-1:0] DUTY_CEIL_RST = DUTY_W'(16384);
    localparam logic [MASK_W-1:0] REV_MASK_RST  = MASK_W'(69);

    // register indexes, taken from paddr word address
    localparam logic REG_DUTY_CEIL = 1'b0;
    localparam logic REG_REV_MASK  = 1'b1;

    // restoring divider: quotient bits resolved per stage
    localparam int DIV_BITS   = DUTY_W;
    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEP;

    // sums, magnitudes, product, divider stages, output
    localparam int LATENCY = 3 + DIV_STAGES + 1;

    // bit t of row a set where the matrix entry for axis a, thruster t is -1
    localparam logic [THRUSTERS-1:0] MIX_NEG [AXES] = '{
        8'h66,   // surge
        8'h0F,   // sway
        8'hC3,   // heave
        8'hCC,   // roll
        8'h5A,   // pitch
        8'h96    // yaw
    };

    typedef struct packed {
        logic [PROD_W-1:0] rem;
        logic [DIV_BITS-1:0] quo;
        logic [MAG_W-1:0]  den;
        logic              neg;
    } t_lane;

endpackage

// ===== hw/rtl/thrust_allocation_mixer.sv =====
// ----------------------------------------------------------------------------
// thrust_allocation_mixer
// Six-axis demand to eight-thruster duty mixer with common ratio-keeping scale.
// ----------------------------------------------------------------------------
//  channel   ports                                     handshake
//  -------   ----------------------------------------  -------------------------
//  command   i_surge_cmd .. i_yaw_cmd                  start & !busy
//  result    o_duty_tlf .. o_duty_trf                  o_done, one cycle
//  config    psel penable pwrite paddr pwdata prdata   APB, pready tied high
//
//  One word enters per cycle; busy stays low. The result strobes after these
//  registers in order: sums, magnitudes and divisor, product, five divider
//  stages of three quotient bits each, output register. The divider pipeline
//  sets the latency. Synchronous active-low reset clears the valid bits and
//  loads the register reset values. The receiver cannot stall, so nothing holds.
// ----------------------------------------------------------------------------
module thrust_allocation_mixer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [thrmix_pkg::CMD_W-1:0] i_surge_cmd,
    input  logic signed [thrmix_pkg::CMD_W-1:0] i_sway_cmd,
    input  logic signed [thrmix_pkg::CMD_W-1:0] i_heave_cmd,
    input  logic signed [thrmix_pkg::CMD_W-1:0] i_roll_cmd,
    input  logic signed [thrmix_pkg::CMD_W-1:0] i_pitch_cmd,
    input  logic signed [thrmix_pkg::CMD_W-1:0] i_yaw_cmd,
    output logic                              o_done,
    output logic signed [thrmix_pkg::OUT_W-1:0] o_duty_tlf,
    output logic signed [thrmix_pkg::OUT_W-1:0] o_duty_tlb,
    output logic signed [thrmix_pkg::OUT_W-1:0] o_duty_blb,
    output logic signed [thrmix_pkg::OUT_W-1:0] o_duty_blf,
    output logic signed [thrmix_pkg::OUT_W-1:0] o_duty_brf,
    output logic signed [thrmix_pkg::OUT_W-1:0] o_duty_brb,
    output logic signed [thrmix_pkg::OUT_W-1:0] o_duty_trb,
    output logic signed [thrmix_pkg::OUT_W-1:0] o_duty_trf,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [thrmix_pkg::APB_AW-1:0]     paddr,
    input  logic [thrmix_pkg::APB_DW-1:0]     pwdata,
    output logic [thrmix_pkg::APB_DW-1:0]     prdata,
    output logic                              pready
);
    import thrmix_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DUTY_W-1:0] r_duty_ceil;
    logic [MASK_W-1:0] r_rev_mask;
    logic              w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_ceil <= DUTY_CEIL_RST;
            r_rev_mask  <= REV_MASK_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_DUTY_CEIL: r_duty_ceil <= pwdata[DUTY_W-1:0];
                REG_REV_MASK:  r_rev_mask  <= pwdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DUTY_CEIL: prdata = {{(APB_DW-DUTY_W){1'b0}}, r_duty_ceil};
            REG_REV_MASK:  prdata = {{(APB_DW-MASK_W){1'b0}}, r_rev_mask};
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // valid chain
    // ------------------------------------------------------------------
    logic                 w_accept;
    logic [LATENCY-1:0]   r_vld;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], w_accept};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: mixing sums
    // ------------------------------------------------------------------
    logic signed [CMD_W-1:0] w_dem [AXES];
    logic signed [SUM_W-1:0] n_sum [THRUSTERS];
    logic signed [SUM_W-1:0] r_sum [THRUSTERS];

    assign w_dem[0] = i_surge_cmd;
    assign w_dem[1] = i_sway_cmd;
    assign w_dem[2] = i_heave_cmd;
    assign w_dem[3] = i_roll_cmd;
    assign w_dem[4] = i_pitch_cmd;
    assign w_dem[5] = i_yaw_cmd;

    always_comb begin
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] ext;
        for (int t = 0; t < THRUSTERS; t++) begin
            acc = '0;
            for (int a = 0; a < AXES; a++) begin
                ext = SUM_W'(w_dem[a]);
                if (MIX_NEG[a][t]) acc = acc - ext;
                else               acc = acc + ext;
            end
            n_sum[t] = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    // ------------------------------------------------------------------
    // stage 2: magnitudes, common divisor, output sign
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] n_mag [THRUSTERS];
    logic [MAG_W-1:0] n_den;
    logic [THRUSTERS-1:0] n_neg;
    logic [MAG_W-1:0] r_mag [THRUSTERS];
    logic [MAG_W-1:0] r_den;
    logic [THRUSTERS-1:0] r_neg;

    always_comb begin
        logic signed [SUM_W-1:0] flip;
        logic [MAG_W-1:0] best;
        best = UNIT_DEMAND;
        for (int t = 0; t < THRUSTERS; t++) begin
            flip     = -r_sum[t];
            n_mag[t] = r_sum[t][SUM_W-1] ? flip[MAG_W-1:0] : r_sum[t][MAG_W-1:0];
            n_neg[t] = r_sum[t][SUM_W-1] ^ r_rev_mask[t];
            if (n_mag[t] > best) best = n_mag[t];
        end
        n_den = best;
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    // ------------------------------------------------------------------
    // stage 3: mag * duty ceiling into divider lane 0
    // stages 4..: three quotient bits per stage
    // ------------------------------------------------------------------
    t_lane r_div [DIV_STAGES+1][THRUSTERS];

    always_ff @(posedge i_clk) begin
        for (int t = 0; t < THRUSTERS; t++) begin
            r_div[0][t].rem <= PROD_W'(r_mag[t]) * PROD_W'(r_duty_ceil);
            r_div[0][t].quo <= '0;
            r_div[0][t].den <= r_den;
            r_div[0][t].neg <= r_neg[t];
        end
    end

    for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
        localparam int HI = DIV_BITS - 1 - DIV_STEP * (s - 1);
        t_lane n_lane [THRUSTERS];

        always_comb begin
            logic [PROD_W-1:0] trial;
            for (int t = 0; t < THRUSTERS; t++) begin
                n_lane[t] = r_div[s-1][t];
                for (int b = 0; b < DIV_STEP; b++) begin
                    trial = PROD_W'(r_div[s-1][t].den) << (HI - b);
                    if (n_lane[t].rem >= trial) begin
                        n_lane[t].rem         = n_lane[t].rem - trial;
                        n_lane[t].quo[HI - b] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_div[s] <= n_lane;
        end
    end

    // ------------------------------------------------------------------
    // output register: apply sign
    // ------------------------------------------------------------------
    logic signed [OUT_W-1:0] n_duty [THRUSTERS];
    logic signed [OUT_W-1:0] r_duty [THRUSTERS];

    always_comb begin
        logic [OUT_W-1:0] mag;
        for (int t = 0; t < THRUSTERS; t++) begin
            mag       = {1'b0, r_div[DIV_STAGES][t].quo};
            n_duty[t] = r_div[DIV_STAGES][t].neg ? -mag : mag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_duty <= n_duty;
    end

    assign o_done     = r_vld[LATENCY-1];
    assign o_duty_tlf = r_duty[0];
    assign o_duty_tlb = r_duty[1];
    assign o_duty_blb = r_duty[2];
    assign o_duty_blf = r_duty[3];
    assign o_duty_brf = r_duty[4];
    assign o_duty_brb = r_duty[5];
    assign o_duty_trb = r_duty[6];
    assign o_duty_trf = r_duty[7];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    logic w_rem_ok;
    logic w_den_ok;

    always_comb begin
        w_rem_ok = 1'b1;
        w_den_ok = (r_den >= UNIT_DEMAND);
        for (int t = 0; t < THRUSTERS; t++) begin
            if (r_div[DIV_STAGES][t].rem >= PROD_W'(r_div[DIV_STAGES][t].den))
                w_rem_ok = 1'b0;
            if (r_mag[t] > r_den)
                w_den_ok = 1'b0;
        end
    end

    a_vld_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] == $past(w_accept & i_rst_n))
        else $error("valid chain does not pick up the accepted word");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LATENCY-2] |-> w_rem_ok)
        else $error("divider remainder not below divisor at last stage");

    a_den_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> w_den_ok)
        else $error("common divisor below a thruster magnitude or unit demand");

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("busy raised while results stream out");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the thrust allocation mixer. It drives six-axis
// demand words with random gaps, predicts the eight scaled thruster duties for
// every accepted word, and compares each strobed result against the oldest
// prediction. Duty ceiling and reverse mask are rewritten over APB between
// phases (with read-back), including their extremes.
// ----------------------------------------------------------------------------
module tb;

    import thrmix_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_WORDS    = 250;

    typedef logic [AXES-1:0][CMD_W-1:0]      t_demand_vec;
    typedef logic [THRUSTERS-1:0][OUT_W-1:0] t_duty_vec;

    // mixing matrix: row per axis, column per thruster
    localparam int THRUST_SIGN [AXES][THRUSTERS] = '{
        '{ 1, -1, -1,  1,  1, -1, -1,  1},
        '{-1, -1, -1, -1,  1,  1,  1,  1},
        '{-1, -1,  1,  1,  1,  1, -1, -1},
        '{ 1,  1, -1, -1,  1,  1, -1, -1},
        '{ 1, -1,  1, -1, -1,  1, -1,  1},
        '{ 1, -1, -1,  1, -1,  1,  1, -1}
    };

    localparam string DUTY_NAME [THRUSTERS] = '{
        "duty_tlf", "duty_tlb", "duty_blb", "duty_blf",
        "duty_brf", "duty_brb", "duty_trb", "duty_trf"
    };

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic signed [CMD_W-1:0]  i_surge_cmd;
    logic signed [CMD_W-1:0]  i_sway_cmd;
    logic signed [CMD_W-1:0]  i_heave_cmd;
    logic signed [CMD_W-1:0]  i_roll_cmd;
    logic signed [CMD_W-1:0]  i_pitch_cmd;
    logic signed [CMD_W-1:0]  i_yaw_cmd;
    logic                     o_done;
    logic signed [OUT_W-1:0]  o_duty_tlf;
    logic signed [OUT_W-1:0]  o_duty_tlb;
    logic signed [OUT_W-1:0]  o_duty_blb;
    logic signed [OUT_W-1:0]  o_duty_blf;
    logic signed [OUT_W-1:0]  o_duty_brf;
    logic signed [OUT_W-1:0]  o_duty_brb;
    logic signed [OUT_W-1:0]  o_duty_trb;
    logic signed [OUT_W-1:0]  o_duty_trf;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_AW-1:0]        paddr;
    logic [APB_DW-1:0]        pwdata;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;

    thrust_allocation_mixer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_surge_cmd (i_surge_cmd),
        .i_sway_cmd  (i_sway_cmd),
        .i_heave_cmd (i_heave_cmd),
        .i_roll_cmd  (i_roll_cmd),
        .i_pitch_cmd (i_pitch_cmd),
        .i_yaw_cmd   (i_yaw_cmd),
        .o_done      (o_done),
        .o_duty_tlf  (o_duty_tlf),
        .o_duty_tlb  (o_duty_tlb),
        .o_duty_blb  (o_duty_blb),
        .o_duty_blf  (o_duty_blf),
        .o_duty_brf  (o_duty_brf),
        .o_duty_brb  (o_duty_brb),
        .o_duty_trb  (o_duty_trb),
        .o_duty_trf  (o_duty_trf),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    logic [DUTY_W-1:0] cfg_duty_ceil;
    logic [MASK_W-1:0] cfg_rev_mask;
    t_duty_vec         pending_duties [$];
    int                mismatch_count;
    int                idle_cycles;
    int                gap_pct;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // scaled duties of all thrusters for one demand word
    function automatic t_duty_vec mix_duties(t_demand_vec dem, logic [DUTY_W-1:0] ceiling,
                                             logic [MASK_W-1:0] rev);
        int          sum [THRUSTERS];
        int unsigned mag [THRUSTERS];
        int unsigned denom;
        int unsigned quo;
        t_duty_vec   res;
        denom = 127;
        for (int t = 0; t < THRUSTERS; t++) begin
            sum[t] = 0;
            for (int a = 0; a < AXES; a++) begin
                sum[t] += THRUST_SIGN[a][t] * int'($signed(dem[a]));
            end
            mag[t] = (sum[t] < 0) ? -sum[t] : sum[t];
            if (mag[t] > denom) begin
                denom = mag[t];
            end
        end
        for (int t = 0; t < THRUSTERS; t++) begin
            quo = (mag[t] * int'(ceiling)) / denom;
            res[t] = ((sum[t] < 0) != rev[t]) ? OUT_W'(0 - quo) : OUT_W'(quo);
        end
        return res;
    endfunction

    function automatic logic [CMD_W-1:0] pick_demand();
        case ($urandom_range(0, 9))
            0:       return 8'h80;
            1:       return 8'h7F;
            2:       return 8'h00;
            3, 4:    return CMD_W'($urandom_range(0, 20) - 10);
            default: return CMD_W'($urandom);
        endcase
    endfunction

    function automatic t_demand_vec random_word();
        t_demand_vec dem;
        int          axis;
        dem = '0;
        // a few single-axis words, the rest fully mixed
        if ($urandom_range(0, 9) == 0) begin
            axis = $urandom_range(0, AXES - 1);
            dem[axis] = pick_demand();
        end else begin
            for (int a = 0; a < AXES; a++) begin
                dem[a] = pick_demand();
            end
        end
        return dem;
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(t_demand_vec dem);
        start       <= 1'b1;
        i_surge_cmd <= dem[0];
        i_sway_cmd  <= dem[1];
        i_heave_cmd <= dem[2];
        i_roll_cmd  <= dem[3];
        i_pitch_cmd <= dem[4];
        i_yaw_cmd   <= dem[5];
        do @(posedge i_clk); while (busy);
        pending_duties.push_back(mix_duties(dem, cfg_duty_ceil, cfg_rev_mask));
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < gap_pct) begin
            n = (r % 8 == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // drop start, drain all results and let the pipeline empty
    task automatic settle();
        start <= 1'b0;
        while (pending_duties.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    // write one register, then read it back
    task automatic cfg_write(logic idx, logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] want;
        logic [APB_DW-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx) << 2;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_DUTY_CEIL) begin
            cfg_duty_ceil = value[DUTY_W-1:0];
            want = APB_DW'(cfg_duty_ceil);
        end else begin
            cfg_rev_mask = value[MASK_W-1:0];
            want = APB_DW'(cfg_rev_mask);
        end
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("register %0d read back 0x%08h, expected 0x%08h", idx, got, want);
            end
        end
    endtask

    task automatic set_config(logic [DUTY_W-1:0] duty, logic [MASK_W-1:0] mask);
        // junk in the upper bits must be dropped by the register
        cfg_write(REG_DUTY_CEIL, {$urandom} << DUTY_W | APB_DW'(duty));
        cfg_write(REG_REV_MASK, {$urandom} << MASK_W | APB_DW'(mask));
    endtask

    // reset values, single axes at both extremes, aligned and small words
    task automatic test_directed();
        t_demand_vec dem;
        gap_pct = 30;
        send_word('0);
        for (int a = 0; a < AXES; a++) begin
            dem = '0;
            dem[a] = 8'h7F;
            send_word(dem);
            idle_gap();
            dem[a] = 8'h80;
            send_word(dem);
            idle_gap();
        end
        send_word({AXES{8'h7F}});
        send_word({AXES{8'h80}});
        // push every term of one thruster to the same sign
        for (int t = 0; t < THRUSTERS; t++) begin
            for (int a = 0; a < AXES; a++) begin
                dem[a] = (THRUST_SIGN[a][t] > 0) ? 8'h80 : 8'h7F;
            end
            send_word(dem);
            idle_gap();
        end
        send_word({8'h02, 8'hFD, 8'h01, 8'h00, 8'hFF, 8'h03});
        send_word({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01});
        settle();
    endtask

    task automatic test_extreme_config();
        set_config('1, '0);
        gap_pct = 0;
        send_word({AXES{8'h7F}});
        for (int a = 0; a < AXES; a++) begin
            send_word(t_demand_vec'(8'h80) << (a * CMD_W));
        end
        send_word({8'h80, 8'h7F, 8'h80, 8'h7F, 8'h80, 8'h7F});
        settle();
        set_config(DUTY_W'(1), '1);
        for (int i = 0; i < 8; i++) begin
            send_word(random_word());
        end
        settle();
    endtask

    task automatic test_zero_ceiling();
        set_config('0, '1);
        gap_pct = 20;
        for (int i = 0; i < 20; i++) begin
            send_word(random_word());
            idle_gap();
        end
        settle();
    endtask

    task automatic test_random();
        logic [DUTY_W-1:0] duty;
        logic [MASK_W-1:0] mask;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       begin duty = '1;              mask = '1;            end
                1:       begin duty = DUTY_W'(1);      mask = '0;            end
                2:       begin duty = DUTY_CEIL_RST;   mask = REV_MASK_RST;  end
                3:       begin duty = '0;              mask = MASK_W'($urandom); end
                default: begin duty = DUTY_W'($urandom); mask = MASK_W'($urandom); end
            endcase
            set_config(duty, mask);
            // every other phase runs back to back
            gap_pct = (p % 2 == 0) ? 0 : $urandom_range(10, 50);
            for (int i = 0; i < PHASE_WORDS; i++) begin
                send_word(random_word());
                idle_gap();
            end
            settle();
        end
    endtask

    // compare every strobed result with the oldest prediction
    always @(posedge i_clk) begin
        t_duty_vec want;
        t_duty_vec got;
        if (i_rst_n && o_done) begin
            got = {o_duty_trf, o_duty_trb, o_duty_brb, o_duty_brf,
                   o_duty_blf, o_duty_blb, o_duty_tlb, o_duty_tlf};
            if (pending_duties.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected result word at %0t", $realtime);
                end
            end else begin
                want = pending_duties.pop_front();
                for (int t = 0; t < THRUSTERS; t++) begin
                    if (got[t] !== want[t]) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("%s mismatch: expected %0d, got %0d",
                                     DUTY_NAME[t], $signed(want[t]), $signed(got[t]));
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (psel && penable && pready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_surge_cmd    = '0;
        i_sway_cmd     = '0;
        i_heave_cmd    = '0;
        i_roll_cmd     = '0;
        i_pitch_cmd    = '0;
        i_yaw_cmd      = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cfg_duty_ceil  = DUTY_CEIL_RST;
        cfg_rev_mask   = REV_MASK_RST;
        mismatch_count = 0;
        idle_cycles    = 0;
        gap_pct        = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_extreme_config();
        test_zero_ceiling();
        test_random();

        // settle() already drained; allow stray strobes to show up
        repeat (LATENCY + 4) @(posedge i_clk);
        mismatch_count += pending_duties.size();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
